/* hdl/dvft_pkg.sv */
// Shared types and helpers for the distinct value frequency table.
package dvft_pkg;

   localparam int VALUE_W = 32;
   localparam int TOTAL_W = 7;
   localparam int RSP_COUNT_W = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   // Sample word travelling down the cell chain
   typedef struct packed {
      logic               valid;
      logic               done;    // matched or stored by an earlier cell
      logic               placed;  // stored as a new entry
      logic [VALUE_W-1:0] value;
   } token_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DRAIN = 3'b010,
      ST_DUMP  = 3'b100
   } state_type;

   function automatic logic is_nan(input logic [VALUE_W-1:0] b);
      is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   // IEEE equality: NaN equals nothing, +0 equals -0
   function automatic logic ieee_equal(input logic [VALUE_W-1:0] a,
                                       input logic [VALUE_W-1:0] b);
      logic [VALUE_W-1:0] both;
      both = a | b;
      if (is_nan(a) || is_nan(b)) begin
         ieee_equal = 1'b0;
      end else if (both[30:0] == 31'd0) begin
         ieee_equal = 1'b1;
      end else begin
         ieee_equal = (a == b);
      end
   endfunction

endpackage

/* hdl/distinct_value_frequency_table_core.sv */
// Distinct value histogram: a chain of match-and-count cells, dumped by shifting out.
//
// An insert (req_op = 0) is accepted every cycle while busy is low; the sample walks
// the chain of TABLE_DEPTH cells, one cell per cycle, and is counted or stored on
// the way, so inserts stream at one word per clock. A dump (req_op = 1) raises busy,
// waits until every insert still in the chain has retired, then shifts the entries
// out of cell 0 at one word per cycle, in order of first appearance, each word
// passing through an output register on its way to the rsp_ ports, with
// rsp_is_last on the final word; busy falls while that final word is on the ports,
// and the table and the overflow flag are then clear. An empty dump produces no
// word. The receiver cannot stall: each word sits on the rsp_ ports for exactly the
// one cycle rsp_valid is high.
module distinct_value_frequency_table_core #(
   parameter int TABLE_DEPTH = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic [dvft_pkg::VALUE_W-1:0]        req_sample_value,
   output logic                                rsp_valid,
   output logic [dvft_pkg::VALUE_W-1:0]        rsp_entry_value,
   output logic [dvft_pkg::RSP_COUNT_W-1:0]    rsp_entry_count,
   output logic [dvft_pkg::TOTAL_W-1:0]        rsp_distinct_total,
   output logic                                rsp_is_last,
   output logic                                rsp_overflowed
);
   import dvft_pkg::*;

   localparam int ENTRY_W = $clog2(TABLE_DEPTH + 1);

   token_type              tok [0:TABLE_DEPTH];
   logic                   cell_valid [0:TABLE_DEPTH];
   logic [VALUE_W-1:0]     cell_value [0:TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] cell_count [0:TABLE_DEPTH];

   state_type              state_ff, state_in;
   logic [ENTRY_W-1:0]     entries_ff, entries_in;
   logic [ENTRY_W-1:0]     flight_ff, flight_in;
   logic [ENTRY_W-1:0]     remain_ff, remain_in;
   logic                   overflow_ff, overflow_in;
   logic                   shift_en;
   logic                   accept, accept_ins;
   token_type              tail;

   logic                   rsp_valid_ff;
   logic [VALUE_W-1:0]     rsp_value_ff;
   logic [RSP_COUNT_W-1:0] rsp_count_ff;
   logic [TOTAL_W-1:0]     rsp_total_ff;
   logic                   rsp_last_ff;
   logic                   rsp_ovf_ff;

   logic [COUNT_WIDTH+RSP_COUNT_W-1:0] count_ext;
   logic [ENTRY_W+TOTAL_W-1:0]         total_ext;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign accept_ins = accept && (req_op == OP_INSERT);

   always_comb begin
      tok[0].valid  = accept_ins;
      tok[0].done   = 1'b0;
      tok[0].placed = 1'b0;
      tok[0].value  = req_sample_value;
   end

   // Past the last cell nothing is held
   assign cell_valid[TABLE_DEPTH] = 1'b0;
   assign cell_value[TABLE_DEPTH] = '0;
   assign cell_count[TABLE_DEPTH] = '0;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      dvft_cell #(
         .COUNT_WIDTH(COUNT_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .tok_in      (tok[k]),
         .tok_out     (tok[k+1]),
         .shift_en    (shift_en),
         .shift_valid (cell_valid[k+1]),
         .shift_value (cell_value[k+1]),
         .shift_count (cell_count[k+1]),
         .entry_valid (cell_valid[k]),
         .entry_value (cell_value[k]),
         .entry_count (cell_count[k])
      );
   end

   assign tail     = tok[TABLE_DEPTH];
   assign shift_en = (state_ff == ST_DUMP);

   always_comb begin
      state_in    = state_ff;
      entries_in  = entries_ff;
      flight_in   = flight_ff;
      remain_in   = remain_ff;
      overflow_in = overflow_ff;

      // retire samples leaving the chain
      if (tail.valid && tail.placed) begin
         entries_in = entries_ff + {{(ENTRY_W-1){1'b0}}, 1'b1};
      end
      if (tail.valid && !tail.done) begin
         overflow_in = 1'b1;
      end
      if (accept_ins && !tail.valid) begin
         flight_in = flight_ff + {{(ENTRY_W-1){1'b0}}, 1'b1};
      end else if (!accept_ins && tail.valid) begin
         flight_in = flight_ff - {{(ENTRY_W-1){1'b0}}, 1'b1};
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_DUMP)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (flight_ff == '0) begin
               remain_in = entries_ff;
               if (entries_ff == '0) begin
                  overflow_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_DUMP;
               end
            end
         end
         ST_DUMP: begin
            remain_in = remain_ff - {{(ENTRY_W-1){1'b0}}, 1'b1};
            if (remain_ff == {{(ENTRY_W-1){1'b0}}, 1'b1}) begin
               entries_in  = '0;
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= '0;
         flight_ff    <= '0;
         remain_ff    <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         flight_ff    <= flight_in;
         remain_ff    <= remain_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= shift_en;
      end
   end

   assign count_ext = {{RSP_COUNT_W{1'b0}}, cell_count[0]};
   assign total_ext = {{TOTAL_W{1'b0}}, entries_ff};

   always_ff @(posedge clock) begin
      rsp_value_ff <= cell_value[0];
      rsp_count_ff <= count_ext[RSP_COUNT_W-1:0];
      rsp_total_ff <= total_ext[TOTAL_W-1:0];
      rsp_last_ff  <= (remain_ff == {{(ENTRY_W-1){1'b0}}, 1'b1});
      rsp_ovf_ff   <= overflow_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_value    = rsp_value_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_distinct_total = rsp_total_ff;
   assign rsp_is_last        = rsp_last_ff;
   assign rsp_overflowed     = rsp_ovf_ff;

endmodule

/* hdl/dvft_cell.sv */
// One entry of the table: holds a value and its count, matches passing samples.
module dvft_cell #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dvft_pkg::token_type             tok_in,
   output dvft_pkg::token_type             tok_out,
   input  logic                            shift_en,
   input  logic                            shift_valid,
   input  logic [dvft_pkg::VALUE_W-1:0]    shift_value,
   input  logic [COUNT_WIDTH-1:0]          shift_count,
   output logic                            entry_valid,
   output logic [dvft_pkg::VALUE_W-1:0]    entry_value,
   output logic [COUNT_WIDTH-1:0]          entry_count
);
   import dvft_pkg::*;

   logic                   valid_ff, valid_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   token_type              tok_ff, tok_in_next;
   logic                   live, hit, place;

   assign live  = tok_in.valid && !tok_in.done;
   assign hit   = live && valid_ff && ieee_equal(tok_in.value, value_ff);
   assign place = live && !valid_ff;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (shift_en) begin
         valid_in = shift_valid;
         value_in = shift_value;
         count_in = shift_count;
      end else if (place) begin
         valid_in = 1'b1;
         value_in = tok_in.value;
         count_in = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      end else if (hit && (count_ff != {COUNT_WIDTH{1'b1}})) begin
         count_in = count_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      end
   end

   always_comb begin
      tok_in_next        = tok_in;
      tok_in_next.done   = tok_in.done | hit | place;
      tok_in_next.placed = tok_in.placed | place;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      value_ff      <= value_in;
      count_ff      <= count_in;
      tok_ff.done   <= tok_in_next.done;
      tok_ff.placed <= tok_in_next.placed;
      tok_ff.value  <= tok_in_next.value;
   end

   assign tok_out     = tok_ff;
   assign entry_valid = valid_ff;
   assign entry_value = value_ff;
   assign entry_count = count_ff;

endmodule

/* hdl/dvft_checker.sv */
// Port-level checks of the frequency table, bound to the top level.
module dvft_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              req_op,
   input logic                              rsp_valid,
   input logic [dvft_pkg::TOTAL_W-1:0]      rsp_distinct_total,
   input logic                              rsp_is_last,
   input logic                              rsp_overflowed
);
   import dvft_pkg::*;

   // a dump run stays busy until its final word
   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> busy)
      else $error("busy low inside a dump run");

   a_run_continuous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |=> rsp_valid)
      else $error("dump run broken before its last word");

   a_run_fields_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |=> $stable(rsp_distinct_total) && $stable(rsp_overflowed))
      else $error("total or overflow changed within a dump run");

   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distinct_total != '0)
      else $error("word emitted with zero total");

   a_insert_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_INSERT) |=> !rsp_valid)
      else $error("word emitted right after an insert");

endmodule

bind distinct_value_frequency_table_core dvft_checker u_dvft_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_op             (req_op),
   .rsp_valid          (rsp_valid),
   .rsp_distinct_total (rsp_distinct_total),
   .rsp_is_last        (rsp_is_last),
   .rsp_overflowed     (rsp_overflowed)
);
